>>> rtl/cursor_text_buffer_macros.svh
// ----------------------------------------------------------------------------
// cursor_text_buffer_macros
// Assertion macros for the cursor text buffer. They expand to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CURSOR_TEXT_BUFFER_MACROS_SVH
`define CURSOR_TEXT_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
`define CTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cursor_text_buffer: assertion failed");
`define CTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cursor_text_buffer: assertion failed");
`else
`define CTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// Types and constants shared by the cursor text buffer and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ctb_pkg;

    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_LEFT   = 3'd2,
        OP_RIGHT  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_LEFT  = 2'd1,
        STS_NO_RIGHT = 2'd2,
        STS_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INSERT,
        CM_DELETE,
        CM_ROTATE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode           mode;
        logic [COUNT_W-1:0]   pos;
        logic [COUNT_W-1:0]   last_idx;
    } t_cell_ctrl;

endpackage

`default_nettype wire

>>> rtl/cursor_text_buffer.sv
// ----------------------------------------------------------------------------
// cursor_text_buffer
// Text buffer with a cursor. The text is kept in reading order in a row of
// byte cells; insert and delete shift the cells right of the cursor by one,
// and a read rotates the used cells past the head cell, one byte per beat.
//
//   channel   direction  handshake              payload
//   command   in         i_start, o_busy        i_operation, i_char_in
//   result    out        o_valid (strobe)       o_status, o_char_out,
//                                               o_char_valid, o_last,
//                                               o_cursor_pos
//
// Edit commands may follow one another every cycle while o_busy is low.
// A read of N bytes gives N result beats, one per cycle, and holds o_busy
// high until the cell row has rotated once around.
// Results appear in the cycle after the command or rotation step that
// makes them. Reset is synchronous and empties the text; cell contents
// are not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cursor_text_buffer_macros.svh"

module cursor_text_buffer
    import ctb_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire  [2:0]           i_operation,
    input  wire  [BYTE_W-1:0]    i_char_in,
    output logic                 o_busy,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [BYTE_W-1:0]    o_char_out,
    output logic                 o_char_valid,
    output logic                 o_last,
    output logic [COUNT_W-1:0]   o_cursor_pos
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE     = CW'(1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_left, n_left;
    logic [CW-1:0]       r_total, n_total;
    logic [CW-1:0]       r_remain, n_remain;
    logic                r_valid, n_valid;
    t_status             r_status, n_status;
    logic [BYTE_W-1:0]   r_char, n_char;
    logic                r_char_valid, n_char_valid;
    logic                r_last, n_last;
    logic [COUNT_W-1:0]  r_cursor, n_cursor;
    t_cell_ctrl          w_ctrl;
    logic [BYTE_W-1:0]   w_cell [CAPACITY];

    always_comb begin
        n_state      = r_state;
        n_left       = r_left;
        n_total      = r_total;
        n_remain     = r_remain;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_char       = r_char;
        n_char_valid = r_char_valid;
        n_last       = r_last;
        n_cursor     = r_cursor;
        w_ctrl       = '{mode: CM_HOLD, pos: '0, last_idx: '0};

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_valid      = 1'b1;
                    n_status     = STS_OK;
                    n_char       = '0;
                    n_char_valid = 1'b0;
                    n_last       = 1'b1;
                    unique case (t_op'(i_operation))
                        OP_INSERT: begin
                            if (r_total == CAP_CNT) begin
                                n_status = STS_FULL;
                            end else begin
                                w_ctrl.mode = CM_INSERT;
                                w_ctrl.pos  = COUNT_W'(r_left);
                                n_left      = r_left + ONE;
                                n_total     = r_total + ONE;
                            end
                        end
                        OP_DELETE: begin
                            if (r_left == '0) begin
                                n_status = STS_NO_LEFT;
                            end else begin
                                w_ctrl.mode = CM_DELETE;
                                w_ctrl.pos  = COUNT_W'(r_left - ONE);
                                n_left      = r_left - ONE;
                                n_total     = r_total - ONE;
                            end
                        end
                        OP_LEFT: begin
                            if (r_left == '0) begin
                                n_status = STS_NO_LEFT;
                            end else begin
                                n_left = r_left - ONE;
                            end
                        end
                        OP_RIGHT: begin
                            if (r_left == r_total) begin
                                n_status = STS_NO_RIGHT;
                            end else begin
                                n_left = r_left + ONE;
                            end
                        end
                        OP_READ: begin
                            if (r_total != '0) begin
                                w_ctrl.mode     = CM_ROTATE;
                                w_ctrl.last_idx = COUNT_W'(r_total - ONE);
                                n_char          = w_cell[0];
                                n_char_valid    = 1'b1;
                                n_remain        = r_total - ONE;
                                n_last          = (r_total == ONE);
                                if (r_total != ONE) begin
                                    n_state = ST_READ;
                                end
                            end
                        end
                        default: begin
                            n_status = STS_OK;
                        end
                    endcase
                    n_cursor = COUNT_W'(n_left);
                end
            end
            ST_READ: begin
                w_ctrl.mode     = CM_ROTATE;
                w_ctrl.last_idx = COUNT_W'(r_total - ONE);
                n_valid         = 1'b1;
                n_status        = STS_OK;
                n_char          = w_cell[0];
                n_char_valid    = 1'b1;
                n_remain        = r_remain - ONE;
                n_last          = (r_remain == ONE);
                n_cursor        = COUNT_W'(r_left);
                if (r_remain == ONE) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_left   <= '0;
            r_total  <= '0;
            r_remain <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_total  <= n_total;
            r_remain <= n_remain;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_char       <= n_char;
        r_char_valid <= n_char_valid;
        r_last       <= n_last;
        r_cursor     <= n_cursor;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [BYTE_W-1:0] w_left_in;
        logic [BYTE_W-1:0] w_right_in;

        if (g == 0) begin : g_first
            assign w_left_in = '0;
        end else begin : g_inner_l
            assign w_left_in = w_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_final
            assign w_right_in = '0;
        end else begin : g_inner_r
            assign w_right_in = w_cell[g+1];
        end

        ctb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_index      (COUNT_W'(g)),
            .i_from_left  (w_left_in),
            .i_from_right (w_right_in),
            .i_from_head  (w_cell[0]),
            .i_char       (i_char_in),
            .o_data       (w_cell[g])
        );
    end

    assign o_busy       = (r_state == ST_READ);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_char_out   = r_char;
    assign o_char_valid = r_char_valid;
    assign o_last       = r_last;
    assign o_cursor_pos = r_cursor;

    `CTB_ASSERT_IMP(a_left_within_total, i_clk, i_rst_n, 1'b1, r_left <= r_total)
    `CTB_ASSERT_IMP(a_total_within_cap, i_clk, i_rst_n, 1'b1, r_total <= CAP_CNT)
    `CTB_ASSERT_IMP(a_read_has_bytes, i_clk, i_rst_n, r_state == ST_READ, r_remain != '0)
    `CTB_ASSERT_NXT(a_accept_gives_beat, i_clk, i_rst_n, i_start && !o_busy, o_valid)

endmodule

`default_nettype wire

>>> rtl/ctb_cell.sv
// ----------------------------------------------------------------------------
// ctb_cell
// One byte of text. Depending on the broadcast command the cell holds its
// byte, takes the byte from its left or right neighbor, takes the inserted
// byte, or takes the head byte to close a rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module ctb_cell
    import ctb_pkg::*;
(
    input  wire                     i_clk,
    input  wire  t_cell_ctrl        i_ctrl,
    input  wire  [COUNT_W-1:0]      i_index,
    input  wire  [BYTE_W-1:0]       i_from_left,
    input  wire  [BYTE_W-1:0]       i_from_right,
    input  wire  [BYTE_W-1:0]       i_from_head,
    input  wire  [BYTE_W-1:0]       i_char,
    output logic [BYTE_W-1:0]       o_data
);

    logic [BYTE_W-1:0] r_data;
    logic [BYTE_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctrl.mode)
            CM_INSERT: begin
                if (i_index == i_ctrl.pos) begin
                    n_data = i_char;
                end else if (i_index > i_ctrl.pos) begin
                    n_data = i_from_left;
                end
            end
            CM_DELETE: begin
                if (i_index >= i_ctrl.pos) begin
                    n_data = i_from_right;
                end
            end
            CM_ROTATE: begin
                if (i_index == i_ctrl.last_idx) begin
                    n_data = i_from_head;
                end else begin
                    n_data = i_from_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire
